>>> sv/rac_pkg.sv
// Package for the rational accumulator ALU: data widths, mode codes and
// error codes. No dependencies.
`default_nettype none

package rac_pkg;

  // Width of numerator and denominator words
  localparam int unsigned DATA_WIDTH = 32;
  // Exact products and sums
  localparam int unsigned WIDE       = 2 * DATA_WIDTH;
  // Quotient bits kept by the divider; anything wider is an overflow anyway
  localparam int unsigned QUO_W      = DATA_WIDTH + 1;
  // Step counter for the multiply steps and the divider iterations
  localparam int unsigned CNT_W      = $clog2(QUO_W + 1);

  // Operation codes on mode_i
  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  // Error codes on error_code_o
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_OVF  = 2'd1;
  localparam logic [1:0] ERR_ZDIV = 2'd2;

endpackage

`default_nettype wire

>>> sv/rational_accumulator_alu.sv
// Rational accumulator ALU top level: sequencer, shared 64-bit add/subtract
// unit, 32x32 multiplier, binary gcd and restoring divider. Uses rac_pkg.
`default_nettype none

// The block holds one fraction num/den (den positive) and applies one input
// transfer to it: load, add, subtract, multiply or divide by the operand
// fraction. Every result is reduced to lowest terms with the sign in the
// numerator and comes out as one output transfer together with an error code:
// 0 ok, 1 the reduced result does not fit 32 bits, 2 zero operand denominator
// (or zero divisor in divide). On an error, and for unused modes 5 to 7, the
// accumulator is kept and shown on the result fields. After reset it is 0/1.
// The block takes one item at a time: in_stall_o is high from the transfer
// until the result has been moved into the output register, which can still
// be waiting on out_stall_i when the next item comes in. An item runs through
// the multiply and sign steps its mode needs, strips common factors of two
// one at a time, then runs the binary gcd loop (one shift, subtract or swap
// per cycle), then two restoring divisions of 33 steps each, with setup and
// finish. Zero divisor items and unused modes skip all of these steps; zero
// results skip the stripping, the gcd loop and the divisions. The gcd loop
// and the divider take turns on the one shared 65-bit subtractor.
module rational_accumulator_alu
  import rac_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [DATA_WIDTH-1:0] operand_num_i,
  input  wire logic [DATA_WIDTH-1:0] operand_den_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      result_num_o,
  output logic [DATA_WIDTH-2:0]      result_den_o,
  output logic [1:0]                 error_code_o
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;  // wait for an input transfer
  localparam logic [3:0] ST_MUL  = 4'd1;  // cross products, one per cycle
  localparam logic [3:0] ST_ADD  = 4'd2;  // signed sum of the two products
  localparam logic [3:0] ST_NEG  = 4'd3;  // fix up a negative difference
  localparam logic [3:0] ST_CHKZ = 4'd4;  // zero numerator short cut
  localparam logic [3:0] ST_TZ   = 4'd5;  // strip common factors of two
  localparam logic [3:0] ST_GCD  = 4'd6;  // odd gcd, Stein style
  localparam logic [3:0] ST_PRE  = 4'd7;  // divider setup and quotient range check
  localparam logic [3:0] ST_DIV  = 4'd8;  // restoring division, one bit a cycle
  localparam logic [3:0] ST_FIN  = 4'd9;  // range check, build result
  localparam logic [3:0] ST_DONE = 4'd10; // hand result to output register

  // Magnitude of a two's complement word (most negative value maps to 2^(W-1))
  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    mag = v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
  endfunction

  logic [3:0]            state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  div_sel_q;   // 0: dividing numerator, 1: denominator

  // Accumulator
  logic [DATA_WIDTH-1:0] acc_num_q;
  logic [DATA_WIDTH-2:0] acc_den_q;

  // Latched item
  logic [2:0]            mode_q;
  logic                  sa_q, so_q, neg_q;
  logic [DATA_WIDTH-1:0] a_q, b_q, c_q, e_q;

  // Working registers
  logic [WIDE-1:0]       n_q, d_q, t2_q, u_q, v_q, rem_q;
  logic [QUO_W-1:0]      quo_q, qn_q;

  // Result waiting for the output register
  logic [DATA_WIDTH-1:0] res_num_q;
  logic [DATA_WIDTH-2:0] res_den_q;
  logic [1:0]            res_err_q;

  // Output register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_num_q;
  logic [DATA_WIDTH-2:0] out_den_q;
  logic [1:0]            out_err_q;

  // Input side helpers
  logic                  in_xfer;
  logic [DATA_WIDTH-1:0] in_c, in_e, in_a;
  logic                  in_so;
  logic                  in_zdiv;
  logic                  out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_c       = mag(operand_num_i);
  assign in_e       = mag(operand_den_i);
  assign in_a       = mag(acc_num_q);
  assign in_so      = operand_num_i[DATA_WIDTH-1] ^ operand_den_i[DATA_WIDTH-1];
  // zero operand denominator in arithmetic modes, zero divisor in divide
  assign in_zdiv    = (((mode_i == MODE_ADD) || (mode_i == MODE_SUB)
                        || (mode_i == MODE_MUL)) && (in_e == '0))
                    || ((mode_i == MODE_DIV) && ((in_e == '0) || (in_c == '0)));
  // result moves into the output register
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------
  // Shared multiplier (32x32, product registered by the sequencer)
  // ---------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] mul_x, mul_y;
  logic [WIDE-1:0]       mul_p;
  logic                  mul_last;
  logic                  is_addsub;

  assign is_addsub = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
  assign mul_last  = is_addsub ? (cnt_q == CNT_W'(2)) : (cnt_q == CNT_W'(1));

  always_comb begin
    mul_x = a_q;
    mul_y = e_q;
    case (cnt_q[1:0])
      2'd0: begin
        // add/sub and divide: a*e, multiply: a*c
        mul_x = a_q;
        mul_y = (mode_q == MODE_MUL) ? c_q : e_q;
      end
      2'd1: begin
        if (is_addsub) begin
          mul_x = c_q;
          mul_y = b_q;
        end else if (mode_q == MODE_DIV) begin
          mul_x = b_q;
          mul_y = c_q;
        end else begin
          mul_x = b_q;
          mul_y = e_q;
        end
      end
      default: begin
        mul_x = b_q;
        mul_y = e_q;
      end
    endcase
  end

  assign mul_p = WIDE'(mul_x) * WIDE'(mul_y);

  // ---------------------------------------------------------------------
  // Shared add/subtract unit
  // ---------------------------------------------------------------------
  logic [WIDE-1:0] alu_x, alu_y;
  logic            alu_sub;
  logic [WIDE:0]   alu_r;
  logic            alu_borrow;
  logic            alu_zero;
  logic            s2;
  logic [WIDE-1:0] dividend;

  assign s2       = (mode_q == MODE_SUB) ? ~so_q : so_q;
  assign dividend = div_sel_q ? d_q : n_q;

  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b1;
    case (state_q)
      ST_ADD: begin
        alu_x   = n_q;
        alu_y   = t2_q;
        alu_sub = sa_q ^ s2;
      end
      ST_NEG: begin
        alu_x = '0;
        alu_y = n_q;
      end
      ST_GCD: begin
        alu_x = u_q;
        alu_y = v_q;
      end
      ST_PRE: begin
        alu_x = WIDE'(dividend[WIDE-1:QUO_W]);
        alu_y = v_q;
      end
      ST_DIV: begin
        alu_x = {rem_q[WIDE-2:0], quo_q[QUO_W-1]};
        alu_y = v_q;
      end
      default: begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_r      = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y}
                    + {{WIDE{1'b0}}, alu_sub};
  assign alu_borrow = alu_sub & ~alu_r[WIDE];
  assign alu_zero   = (alu_r[WIDE-1:0] == '0);

  // Divider step result and final range checks
  logic [QUO_W-1:0] quo_nx;
  logic             fits_n, fits_d;

  assign quo_nx = {quo_q[QUO_W-2:0], ~alu_borrow};
  assign fits_d = (quo_q[QUO_W-1:DATA_WIDTH-1] == '0);
  assign fits_n = neg_q ? (!qn_q[QUO_W-1] && (!qn_q[DATA_WIDTH-1]
                           || (qn_q[DATA_WIDTH-2:0] == '0)))
                        : (qn_q[QUO_W-1:DATA_WIDTH-1] == '0);

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_num_q   <= '0;
      acc_den_q   <= (DATA_WIDTH-1)'(1);
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt_q <= '0;
            case (mode_i)
              MODE_LOAD: state_q <= ST_CHKZ;
              MODE_ADD, MODE_SUB, MODE_MUL: begin
                state_q <= (in_e == '0) ? ST_DONE : ST_MUL;
              end
              MODE_DIV: begin
                state_q <= ((in_e == '0) || (in_c == '0)) ? ST_DONE : ST_MUL;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (mul_last) begin
            state_q <= is_addsub ? ST_ADD : ST_CHKZ;
          end
        end
        ST_ADD: state_q <= (alu_sub && alu_borrow) ? ST_NEG : ST_CHKZ;
        ST_NEG: state_q <= ST_CHKZ;
        ST_CHKZ: state_q <= (n_q == '0) ? ST_DONE : ST_TZ;
        ST_TZ: begin
          if (n_q[0] || d_q[0]) begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (u_q[0] && v_q[0] && !alu_borrow && alu_zero) begin
            div_sel_q <= 1'b0;
            state_q   <= ST_PRE;
          end
        end
        ST_PRE: begin
          cnt_q   <= '0;
          state_q <= alu_borrow ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(QUO_W - 1)) begin
            if (!div_sel_q) begin
              div_sel_q <= 1'b1;
              state_q   <= ST_PRE;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_load) begin
            if (res_err_q == ERR_OK) begin
              acc_num_q <= res_num_q;
              acc_den_q <= res_den_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_q    <= mode_i;
          sa_q      <= acc_num_q[DATA_WIDTH-1];
          so_q      <= in_so;
          neg_q     <= (mode_i == MODE_LOAD) ? in_so
                                             : (acc_num_q[DATA_WIDTH-1] ^ in_so);
          a_q       <= in_a;
          b_q       <= DATA_WIDTH'(acc_den_q);
          c_q       <= in_c;
          e_q       <= in_e;
          n_q       <= WIDE'(in_c);
          d_q       <= (in_e == '0) ? WIDE'(1) : WIDE'(in_e);
          // kept accumulator, for errors and unused modes
          res_num_q <= acc_num_q;
          res_den_q <= acc_den_q;
          res_err_q <= in_zdiv ? ERR_ZDIV : ERR_OK;
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          n_q <= mul_p;
        end else if (mul_last) begin
          d_q <= mul_p;
        end else begin
          t2_q <= mul_p;
        end
      end
      ST_ADD: begin
        n_q   <= alu_r[WIDE-1:0];
        neg_q <= (alu_sub && alu_borrow) ? s2 : sa_q;
      end
      ST_NEG: n_q <= alu_r[WIDE-1:0];
      ST_CHKZ: begin
        if (n_q == '0) begin
          res_num_q <= '0;
          res_den_q <= (DATA_WIDTH-1)'(1);
          res_err_q <= ERR_OK;
        end
      end
      ST_TZ: begin
        if (!n_q[0] && !d_q[0]) begin
          n_q <= n_q >> 1;
          d_q <= d_q >> 1;
        end else begin
          u_q <= n_q;
          v_q <= d_q;
        end
      end
      ST_GCD: begin
        // on exit v_q holds the gcd
        if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (alu_borrow) begin
          u_q <= v_q;
          v_q <= u_q;
        end else if (!alu_zero) begin
          u_q <= alu_r[WIDE-1:0] >> 1;
        end
      end
      ST_PRE: begin
        rem_q <= alu_x;
        quo_q <= dividend[QUO_W-1:0];
        if (!alu_borrow) begin
          res_err_q <= ERR_OVF;
        end
      end
      ST_DIV: begin
        rem_q <= alu_borrow ? alu_x : alu_r[WIDE-1:0];
        quo_q <= quo_nx;
        if (!div_sel_q && (cnt_q == CNT_W'(QUO_W - 1))) begin
          qn_q <= quo_nx;
        end
      end
      ST_FIN: begin
        if (fits_n && fits_d) begin
          res_num_q <= neg_q ? (~qn_q[DATA_WIDTH-1:0] + DATA_WIDTH'(1))
                             : qn_q[DATA_WIDTH-1:0];
          res_den_q <= quo_q[DATA_WIDTH-2:0];
        end else begin
          res_err_q <= ERR_OVF;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_num_q <= res_num_q;
          out_den_q <= res_den_q;
          out_err_q <= res_err_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign result_num_o = out_num_q;
  assign result_den_o = out_den_q;
  assign error_code_o = out_err_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_acc_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_den_q != '0)
    else $error("accumulator denominator is zero");

  a_gcd_operands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> ((u_q != '0) && (v_q != '0)))
    else $error("gcd operand reached zero");

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < v_q))
    else $error("divider remainder not below divisor");

  a_zero_is_canonical : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_num_o == '0)) |-> (result_den_o == (DATA_WIDTH-1)'(1)))
    else $error("zero result not reduced to 0/1");

  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken again before item finished");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for rational_accumulator_alu: directed and random fraction operations,
// each result checked against an in-bench fraction predictor.
// Depends on rac_pkg and the rational_accumulator_alu RTL.
`default_nettype none

module tb;
  import rac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Modes 5 to 7 are not decoded by the block: the accumulator is kept.
  localparam logic [2:0]  MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  MODE_UNUSED_LAST  = 3'd7;

  // Corner values of a 32-bit signed word.
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

  // Largest magnitude that fits on each side of the reduced fraction.
  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

  // Idle wait at the end, so that a stray extra result transfer is seen.
  localparam int unsigned DRAIN_CYCLES  = 400;
  localparam int unsigned ITEMS_PER_RUN = 150;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  err;
  } frac_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  mode_i;
  logic [31:0] operand_num_i;
  logic [31:0] operand_den_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_num_o;
  logic [30:0] result_den_o;
  logic [1:0]  error_code_o;

  // Predictor copy of the accumulator fraction, denominator always positive.
  logic [31:0] frac_num;
  logic [31:0] frac_den;

  // Results still owed by the block, oldest first.
  frac_result_t pending_results[$];

  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  rational_accumulator_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .operand_num_i (operand_num_i),
    .operand_den_i (operand_den_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_num_o  (result_num_o),
    .result_den_o  (result_den_o),
    .error_code_o  (error_code_o)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Fraction predictor. Magnitudes are kept in 64 bits: the widest
  // intermediate is a sum of two products of 31-bit-plus-one magnitudes,
  // which stays below 2^64.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Magnitude of a two's complement word; WORD_MIN gives 2^31.
  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
  endfunction

  // Reduce sign/n/d to lowest terms and store it if it fits; d is nonzero.
  function automatic logic [1:0] store_reduced(input logic neg, input logic [63:0] n,
                                               input logic [63:0] d);
    logic [63:0] g;
    if (n == 64'd0) begin
      neg = 1'b0;
      d   = 64'd1;
    end else begin
      g = euclid_gcd(n, d);
      n = n / g;
      d = d / g;
    end
    if (d > POS_LIMIT) return ERR_OVF;
    if (neg ? (n > NEG_LIMIT) : (n > POS_LIMIT)) return ERR_OVF;
    frac_num = neg ? (~n[31:0] + 32'd1) : n[31:0];
    frac_den = d[31:0];
    return ERR_OK;
  endfunction

  function automatic frac_result_t predict_fraction_step(input logic [2:0] mode,
                                                         input logic [31:0] onum,
                                                         input logic [31:0] oden);
    logic         acc_neg, op_neg, rhs_neg, sum_neg;
    logic [63:0]  acc_n, acc_d, op_n, op_d, g, t1, t2, d, n;
    logic [1:0]   err;
    frac_result_t r;
    acc_neg = frac_num[31];
    acc_n   = magnitude(frac_num);
    acc_d   = {32'd0, frac_den};
    op_neg  = onum[31] ^ oden[31];
    op_n    = magnitude(onum);
    op_d    = magnitude(oden);
    err     = ERR_OK;
    case (mode)
      MODE_LOAD: begin
        // zero denominator on load reads as 1
        err = store_reduced(op_neg, op_n, (op_d == 64'd0) ? 64'd1 : op_d);
      end
      MODE_ADD, MODE_SUB: begin
        if (op_d == 64'd0) begin
          err = ERR_ZDIV;
        end else begin
          g       = euclid_gcd(acc_d, op_d);
          t1      = acc_n * (op_d / g);
          t2      = op_n * (acc_d / g);
          d       = (acc_d / g) * op_d;
          rhs_neg = (mode == MODE_SUB) ? !op_neg : op_neg;
          if (acc_neg == rhs_neg) begin
            n       = t1 + t2;
            sum_neg = acc_neg;
          end else if (t1 >= t2) begin
            n       = t1 - t2;
            sum_neg = acc_neg;
          end else begin
            n       = t2 - t1;
            sum_neg = rhs_neg;
          end
          err = store_reduced(sum_neg, n, d);
        end
      end
      MODE_MUL: begin
        if (op_d == 64'd0) err = ERR_ZDIV;
        else err = store_reduced(acc_neg != op_neg, acc_n * op_n, acc_d * op_d);
      end
      MODE_DIV: begin
        if (op_d == 64'd0 || op_n == 64'd0) err = ERR_ZDIV;
        else err = store_reduced(acc_neg != op_neg, acc_n * op_d, acc_d * op_n);
      end
      default: ;
    endcase
    r.num = frac_num;
    r.den = frac_den[30:0];
    r.err = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side. Inputs change on the falling edge; a transfer is seen at
  // the rising edge with in_valid_i high and in_stall_o low. Each call drives
  // valid exactly once per falling edge, so back-to-back items never lower
  // and raise valid in the same step.
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [2:0] mode, input logic [31:0] onum,
                           input logic [31:0] oden);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    operand_num_i <= onum;
    operand_den_i <= oden;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_results.push_back(predict_fraction_step(mode, onum, oden));
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checking: every output transfer is matched with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    frac_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t ns: result transfer with none pending, expected nothing, actual %0d/%0d",
                 $time, $signed(result_num_o), result_den_o);
      end else begin
        want = pending_results.pop_front();
        check_field("result_num", longint'($signed(want.num)), longint'($signed(result_num_o)));
        check_field("result_den", longint'(want.den), longint'(result_den_o));
        check_field("error_code", longint'(want.err), longint'(error_code_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operand generator. Mostly small values so that chains of operations stay
  // in range; others are full-width words, corners, powers of two, -1000..1000.
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_operand(input int unsigned wild_pct);
    if ($urandom_range(99) < wild_pct) begin
      case ($urandom_range(3))
        0: return $urandom;
        1: begin
          case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return -32'sd1;
            3: return WORD_MIN;
            4: return WORD_MAX;
            default: return WORD_MIN + 32'd1;
          endcase
        end
        2: return ($urandom_range(1) != 0) ? (32'd1 << $urandom_range(31))
                                           : -(32'd1 << $urandom_range(31));
        default: return 32'(int'($urandom_range(2000)) - 1000);
      endcase
    end
    return 32'(int'($urandom_range(40)) - 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load: zero denominator, sign moved up, reduction, both overflow sides.
  task automatic test_load();
    send_item(MODE_LOAD, 32'd7, 32'd0);
    send_item(MODE_LOAD, 32'd6, -32'sd4);
    send_item(MODE_LOAD, 32'd0, -32'sd5);
    send_item(MODE_LOAD, WORD_MIN, 32'd1);
    send_item(MODE_LOAD, WORD_MIN, -32'sd1);
    send_item(MODE_LOAD, WORD_MAX, WORD_MIN);
    send_item(MODE_LOAD, WORD_MIN, WORD_MIN);
  endtask

  // Add and subtract: equal denominators, cross terms, cancel to zero, overflow.
  task automatic test_add_sub();
    send_item(MODE_LOAD, 32'd1, 32'd3);
    send_item(MODE_ADD,  32'd1, 32'd3);
    send_item(MODE_ADD,  32'd1, 32'd6);
    send_item(MODE_SUB,  32'd5, 32'd6);
    send_item(MODE_LOAD, WORD_MAX, 32'd1);
    send_item(MODE_ADD,  32'd1, 32'd1);
    send_item(MODE_SUB,  -32'sd1, -32'sd1);
  endtask

  // Multiply and divide, including results at the edges of the range.
  task automatic test_mul_div();
    send_item(MODE_LOAD, 32'd3, 32'd4);
    send_item(MODE_MUL,  -32'sd4, 32'd3);
    send_item(MODE_DIV,  -32'sd1, 32'd2);
    send_item(MODE_MUL,  WORD_MAX, -32'sd1);
    send_item(MODE_DIV,  WORD_MIN, WORD_MAX);
  endtask

  // Zero operand denominator in arithmetic modes, zero divisor in divide.
  task automatic test_zero_divisor();
    send_item(MODE_ADD, 32'd1, 32'd0);
    send_item(MODE_SUB, 32'd1, 32'd0);
    send_item(MODE_MUL, 32'd1, 32'd0);
    send_item(MODE_DIV, 32'd2, 32'd0);
    send_item(MODE_DIV, 32'd0, 32'd5);
  endtask

  task automatic test_unused_modes();
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
      send_item(3'(m), $urandom, $urandom);
  endtask

  // Random chains: a load followed by a few arithmetic steps, with the odd
  // unused mode or stray load thrown in. Unused modes do not count.
  task automatic test_random_chains(input int unsigned idle, input int unsigned stall);
    int unsigned sent;
    logic [2:0]  mode;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < ITEMS_PER_RUN) begin
      send_item(MODE_LOAD, pick_operand(15), pick_operand(15));
      sent++;
      repeat ($urandom_range(8, 2)) begin
        case ($urandom_range(19))
          0:       mode = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
          1:       mode = MODE_LOAD;
          default: mode = 3'($urandom_range(MODE_DIV, MODE_ADD));
        endcase
        send_item(mode, pick_operand(20), pick_operand(20));
        if (mode <= MODE_DIV) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_LOAD;
    operand_num_i   = 32'd0;
    operand_den_i   = 32'd0;
    out_stall_i     = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    fail_count      = 0;
    frac_num        = 32'd0;
    frac_den        = 32'd1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part runs with neither side idling
    test_load();
    test_add_sub();
    test_mul_div();
    test_zero_divisor();
    test_unused_modes();

    test_random_chains(0, 0);
    test_random_chains(63, 0);
    test_random_chains(0, 63);
    test_random_chains(31, 31);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_results();
    // anything extra the block sends after this is caught by the checker
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: the real run needs well under a millisecond.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
